FILE: design/gmr_pkg.sv
// ----------------------------------------------------------------------------
// gmr_pkg
// Shared constants and command/status types for the movement range block.
// ----------------------------------------------------------------------------
`default_nettype none

package gmr_pkg;

  localparam int GRID_W  = 8;
  localparam int GRID_H  = 8;
  localparam int CELLS   = GRID_W * GRID_H;
  localparam int IDX_W   = $clog2(CELLS);
  localparam int COORD_W = 3;
  localparam int EC_W    = 4;
  localparam int COST_W  = 8;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic load;   // write one cell
    logic init;   // start a query at the input origin
    logic relax;  // one parallel relaxation step
    logic scan;   // emission scan step
  } gmr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic query;      // input beat is a query
    logic origin_ok;  // input coordinates lie on the grid
    logic changed;    // a relaxation step would reach or lower some cell
    logic left;       // reached cells not yet emitted
  } gmr_sts_t;

endpackage

`default_nettype wire

FILE: design/gmr_ctrl.sv
// ----------------------------------------------------------------------------
// gmr_ctrl
// Sequencer: idle/load, relaxation until stable, emission scan.
// ----------------------------------------------------------------------------
`default_nettype none

module gmr_ctrl
  import gmr_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire gmr_sts_t sts_i,
  output gmr_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RELAX = 3'b010,
    ST_EMIT  = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && sts_i.origin_ok) begin
          if (sts_i.query) begin
            cmd_o.init = 1'b1;
            state_d    = ST_RELAX;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      ST_RELAX: begin
        cmd_o.relax = 1'b1;
        if (!sts_i.changed) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.scan = 1'b1;
        if (!sts_i.left) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

endmodule

`default_nettype wire

FILE: design/gmr_datapath.sv
// ----------------------------------------------------------------------------
// gmr_datapath
// Cell array with parallel relaxation, cost-ordered scan and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gmr_datapath
  import gmr_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire gmr_cmd_t           cmd_i,
  output gmr_sts_t                sts_o,
  input  wire logic               kind_i,
  input  wire logic [COORD_W-1:0] col_i,
  input  wire logic [COORD_W-1:0] row_i,
  input  wire logic               blocked_i,
  input  wire logic [EC_W-1:0]    entry_cost_i,
  input  wire logic [COST_W-1:0]  budget_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [COORD_W-1:0]      out_col_o,
  output logic [COORD_W-1:0]      out_row_o,
  output logic [COST_W-1:0]       reach_cost_o,
  output logic                    last_o
);

  logic              blocked_q [CELLS];
  logic [EC_W-1:0]   ecost_q   [CELLS];
  logic [COST_W-1:0] best_q    [CELLS];
  logic [CELLS-1:0]  reached_q, emitted_q;
  logic [COST_W-1:0] budget_q, scan_cost_q;

  // output register
  logic               out_valid_q;
  logic [COORD_W-1:0] out_col_q, out_row_q;
  logic [COST_W-1:0]  reach_cost_q;
  logic               last_q;

  logic [IDX_W-1:0]  in_idx;
  logic [CELLS-1:0]  upd;
  logic [COST_W-1:0] new_cost [CELLS];

  assign in_idx = IDX_W'(int'(row_i) * GRID_W + int'(col_i));

  // neighbor taps, wired at elaboration
  logic              nb_ok   [CELLS][8];
  logic [COST_W-1:0] nb_cost [CELLS][8];

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    localparam int R = i / GRID_W;
    localparam int C = i % GRID_W;
    for (genvar k = 0; k < 8; k++) begin : g_nb
      localparam int KK = (k < 4) ? k : k + 1;
      localparam int NR = R + KK / 3 - 1;
      localparam int NC = C + KK % 3 - 1;
      if (NR >= 0 && NR < GRID_H && NC >= 0 && NC < GRID_W) begin : g_in
        assign nb_ok[i][k]   = reached_q[NR * GRID_W + NC];
        assign nb_cost[i][k] = best_q[NR * GRID_W + NC];
      end else begin : g_out
        assign nb_ok[i][k]   = 1'b0;
        assign nb_cost[i][k] = '0;
      end
    end

    logic [COST_W:0] step, cand, lim;
    logic            found;
    always_comb begin
      step  = (ecost_q[i] == '0) ? (COST_W+1)'(1) : (COST_W+1)'(ecost_q[i]);
      lim   = {1'b0, budget_q};
      found = 1'b0;
      cand  = '0;
      for (int k = 0; k < 8; k++) begin
        if (nb_ok[i][k] && ({1'b0, nb_cost[i][k]} + step <= lim) &&
            (!found || ({1'b0, nb_cost[i][k]} + step < cand))) begin
          found = 1'b1;
          cand  = {1'b0, nb_cost[i][k]} + step;
        end
      end
      upd[i]      = found && !blocked_q[i] &&
                    (!reached_q[i] || cand[COST_W-1:0] < best_q[i]);
      new_cost[i] = cand[COST_W-1:0];
    end
  end

  // emission pick: lowest index at the current scan cost
  logic [CELLS-1:0] pend, hits;
  logic             hit;
  logic [IDX_W-1:0] pick;
  logic             slot_free;

  assign pend      = reached_q & ~emitted_q;
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    hit  = 1'b0;
    pick = '0;
    for (int i = CELLS - 1; i >= 0; i--) begin
      hits[i] = pend[i] && (best_q[i] == scan_cost_q);
      if (hits[i]) begin
        hit  = 1'b1;
        pick = IDX_W'(i);
      end
    end
  end

  assign sts_o.query     = (kind_i == KIND_QUERY);
  assign sts_o.origin_ok = (int'(col_i) < GRID_W) && (int'(row_i) < GRID_H);
  assign sts_o.changed   = |upd;
  assign sts_o.left      = |pend;

  assign out_valid_o  = out_valid_q;
  assign out_col_o    = out_col_q;
  assign out_row_o    = out_row_q;
  assign reach_cost_o = reach_cost_q;
  assign last_o       = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CELLS; i++) begin
        blocked_q[i] <= 1'b0;
        ecost_q[i]   <= '0;
      end
      reached_q   <= '0;
      emitted_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        blocked_q[in_idx] <= blocked_i;
        ecost_q[in_idx]   <= entry_cost_i;
      end
      if (cmd_i.init) begin
        reached_q <= CELLS'(1) << in_idx;
        emitted_q <= '0;
      end else if (cmd_i.relax) begin
        reached_q <= reached_q | upd;
      end
      if (cmd_i.scan && slot_free && hit) begin
        emitted_q[pick] <= 1'b1;
        out_valid_q     <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      best_q[in_idx] <= '0;
      budget_q       <= budget_i;
      scan_cost_q    <= '0;
    end
    if (cmd_i.relax) begin
      for (int i = 0; i < CELLS; i++) begin
        if (upd[i]) best_q[i] <= new_cost[i];
      end
    end
    if (cmd_i.scan && slot_free) begin
      if (hit) begin
        out_col_q    <= COORD_W'(int'(pick) % GRID_W);
        out_row_q    <= COORD_W'(int'(pick) / GRID_W);
        reach_cost_q <= scan_cost_q;
        last_q       <= ((pend & ~(CELLS'(1) << pick)) == '0);
      end else begin
        scan_cost_q  <= scan_cost_q + COST_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/grid_movement_range.sv
// ----------------------------------------------------------------------------
// grid_movement_range
// Least-cost 8-neighbor movement range over a small loadable grid.
// ----------------------------------------------------------------------------
// A load beat (kind 0) writes one cell's blocked bit and entry cost;
// loads stream at one per cycle. A query beat (kind 1) runs a parallel
// relaxation of all cells, one step per cycle, until no cell improves,
// then scans costs from 0 upward, one cost value or one emitted cell per
// cycle while the output register is free to take a cell. The next input
// beat is taken once the sequencer, seeing no pending cells after the last
// result enters the output register, returns to idle. Off-grid loads and
// queries are accepted and dropped.
`default_nettype none

module grid_movement_range
  import gmr_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               kind_i,
  input  wire logic [COORD_W-1:0] col_i,
  input  wire logic [COORD_W-1:0] row_i,
  input  wire logic               blocked_i,
  input  wire logic [EC_W-1:0]    entry_cost_i,
  input  wire logic [COST_W-1:0]  budget_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [COORD_W-1:0]      out_col_o,
  output logic [COORD_W-1:0]      out_row_o,
  output logic [COST_W-1:0]       reach_cost_o,
  output logic                    last_o
);

  gmr_cmd_t cmd;
  gmr_sts_t sts;

  // sequencer
  gmr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // cell array, relaxation, emission
  gmr_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .kind_i       (kind_i),
    .col_i        (col_i),
    .row_i        (row_i),
    .blocked_i    (blocked_i),
    .entry_cost_i (entry_cost_i),
    .budget_i     (budget_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_col_o    (out_col_o),
    .out_row_o    (out_row_o),
    .reach_cost_o (reach_cost_o),
    .last_o       (last_o)
  );

  // idle means every reached cell has been emitted
  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !sts.left)
    else $error("input ready with cells still pending");

  // a query start is followed by relaxation
  a_init_relax: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.init |=> cmd.relax)
    else $error("query start not followed by relaxation");

  // no load or start while busy
  a_busy_no_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.relax || cmd.scan) |-> !(cmd.load || cmd.init))
    else $error("input command while busy");

endmodule

`default_nettype wire

FILE: test/grid_movement_range_test.sv
// ----------------------------------------------------------------------------
// grid_movement_range_test
// Self-checking bench: loads grid cells and runs range queries, predicting the
// reached cells in emission order and comparing every output beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module grid_movement_range_test;
  import gmr_pkg::*;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [COST_W-1:0]  cost;
    logic               last;
  } reach_beat_t;

  typedef struct {
    logic               kind;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               blocked;
    logic [EC_W-1:0]    ecost;
    logic [COST_W-1:0]  budget;
    int                 n_typed;  // typed results (-1: none, predictor only)
    reach_beat_t        typed;    // single typed result when n_typed == 1
  } stim_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               kind_i = 1'b0;
  logic [COORD_W-1:0] col_i = '0;
  logic [COORD_W-1:0] row_i = '0;
  logic               blocked_i = 1'b0;
  logic [EC_W-1:0]    entry_cost_i = '0;
  logic [COST_W-1:0]  budget_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [COORD_W-1:0] out_col_o;
  logic [COORD_W-1:0] out_row_o;
  logic [COST_W-1:0]  reach_cost_o;
  logic               last_o;

  grid_movement_range dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the grid and the queue of expected reached cells
  logic        blk_shadow  [CELLS];
  logic [3:0]  cost_shadow [CELLS];
  reach_beat_t reach_q[$];
  int          errors = 0;
  int          n_loads = 0;
  int          n_queries = 0;
  int          n_beats = 0;
  bit          hold_off = 1'b0;
  int          rx_stall = 0;

  // Dijkstra over the 8-neighbor grid, then emit by cost, row, column
  task automatic predict_range(input int oc, input int orow, input int bud);
    int  best [CELLS];
    bit  seen [CELLS];
    bit  fin  [CELLS];
    int  pick, pc, nr, nc, ni, tc, ec, cnt, lastpos;
    for (int i = 0; i < CELLS; i++) begin
      seen[i] = 0;
      fin[i]  = 0;
      best[i] = 0;
    end
    seen[orow*GRID_W+oc] = 1;
    forever begin
      pick = -1;
      pc = 0;
      for (int i = 0; i < CELLS; i++)
        if (seen[i] && !fin[i] && (pick < 0 || best[i] < pc)) begin
          pick = i;
          pc = best[i];
        end
      if (pick < 0) break;
      fin[pick] = 1;
      if (pc >= bud) continue;
      for (int dr = -1; dr <= 1; dr++)
        for (int dc = -1; dc <= 1; dc++) begin
          nr = pick / GRID_W + dr;
          nc = pick % GRID_W + dc;
          if ((dr == 0 && dc == 0) || nr < 0 || nr >= GRID_H || nc < 0 || nc >= GRID_W)
            continue;
          ni = nr * GRID_W + nc;
          if (blk_shadow[ni]) continue;
          ec = (cost_shadow[ni] == 0) ? 1 : cost_shadow[ni];
          tc = pc + ec;
          if (tc > bud || (seen[ni] && best[ni] <= tc)) continue;
          seen[ni] = 1;
          best[ni] = tc;
        end
    end
    cnt = 0;
    for (int cst = 0; cst <= bud; cst++)
      for (int i = 0; i < CELLS; i++)
        if (seen[i] && best[i] == cst) begin
          reach_q.insert(reach_q.size(),
                         reach_beat_t'{col: i % GRID_W, row: i / GRID_W, cost: cst,
                                       last: 1'b0});
          cnt++;
        end
    lastpos = reach_q.size() - 1;
    if (cnt > 0) reach_q[lastpos].last = 1'b1;
  endtask

  task automatic apply_item(input stim_row_t s);
    int before_n;
    if (s.kind == KIND_LOAD) begin
      blk_shadow[s.row*GRID_W+s.col]  = s.blocked;
      cost_shadow[s.row*GRID_W+s.col] = s.ecost;
      n_loads++;
    end else begin
      before_n = reach_q.size();
      predict_range(s.col, s.row, s.budget);
      n_queries++;
      // Rows with a typed answer cross-check the predictor
      if (s.n_typed == 1 && (reach_q.size() != before_n + 1 || reach_q[before_n] != s.typed))
      begin
        $error("typed row: expected %p, predictor disagrees", s.typed);
        errors++;
      end
    end
  endtask

  // Send one beat; valid stays up until accepted
  task automatic send_beat(input stim_row_t s);
    in_valid_i   <= 1'b1;
    kind_i       <= s.kind;
    col_i        <= s.col;
    row_i        <= s.row;
    blocked_i    <= s.blocked;
    entry_cost_i <= s.ecost;
    budget_i     <= s.budget;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    apply_item(s);
  endtask

  task automatic idle_gap();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) g = 0;
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic drain_wait();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (reach_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic stim_row_t mk(input logic k, input int c, input int r, input logic b,
                                   input int e, input int bud);
    stim_row_t s;
    s = '{kind: k, col: c, row: r, blocked: b, ecost: e, budget: bud, n_typed: -1,
          typed: '0};
    return s;
  endfunction

  function automatic stim_row_t rand_item(input int qpct);
    stim_row_t s;
    int bud;
    bud = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
    s = mk(($urandom_range(0, 99) < qpct) ? KIND_QUERY : KIND_LOAD, $urandom_range(0, 7),
           $urandom_range(0, 7), $urandom_range(0, 4) == 0, $urandom_range(0, 15), bud);
    return s;
  endfunction

  // Output side: random stalls, occasional long ones, plus one long hold-off
  always @(posedge clk_i) begin
    reach_beat_t exp_b;
    if (out_valid_o && out_ready_i) begin
      n_beats++;
      if (reach_q.size() == 0) begin
        $error("unexpected beat col %0d row %0d", out_col_o, out_row_o);
        errors++;
      end else begin
        exp_b = reach_q[0];
        reach_q.delete(0);
        if (out_col_o !== exp_b.col) begin
          $error("out_col: expected %0d, got %0d", exp_b.col, out_col_o); errors++;
        end
        if (out_row_o !== exp_b.row) begin
          $error("out_row: expected %0d, got %0d", exp_b.row, out_row_o); errors++;
        end
        if (reach_cost_o !== exp_b.cost) begin
          $error("reach_cost: expected %0d, got %0d", exp_b.cost, reach_cost_o); errors++;
        end
        if (last_o !== exp_b.last) begin
          $error("last: expected %0d, got %0d", exp_b.last, last_o); errors++;
        end
      end
    end
    if (rx_stall > 0) rx_stall--;
    else if ($urandom_range(0, 63) == 0) rx_stall = $urandom_range(10, 30);
    out_ready_i <= !hold_off && (rx_stall == 0) &&
                   ($urandom_range(0, 15) == 0 ? 1'b0 : $urandom_range(0, 3) != 0);
  end

  initial begin
    stim_row_t tbl[$];
    stim_row_t s;
    for (int i = 0; i < CELLS; i++) begin
      blk_shadow[i] = 0;
      cost_shadow[i] = 0;
    end
    // Directed table: fresh grid, corners, extremes, blocked origin
    s = mk(KIND_QUERY, 3, 4, 0, 0, 0);
    s.n_typed = 1; s.typed = '{col: 3, row: 4, cost: 0, last: 1};
    tbl.insert(tbl.size(), s);                                // budget zero
    tbl.insert(tbl.size(), mk(KIND_QUERY, 0, 0, 1, 15, 1));
    tbl.insert(tbl.size(), mk(KIND_QUERY, 7, 7, 0, 0, 255));  // whole grid
    tbl.insert(tbl.size(), mk(KIND_LOAD, 1, 0, 1, 0, 0));
    tbl.insert(tbl.size(), mk(KIND_LOAD, 1, 1, 1, 15, 0));
    tbl.insert(tbl.size(), mk(KIND_LOAD, 0, 1, 0, 15, 0));
    tbl.insert(tbl.size(), mk(KIND_QUERY, 0, 0, 0, 0, 14));   // neighbor too dear
    tbl.insert(tbl.size(), mk(KIND_QUERY, 0, 0, 1, 7, 15));
    tbl.insert(tbl.size(), mk(KIND_LOAD, 0, 1, 1, 0, 0));
    s = mk(KIND_QUERY, 0, 0, 0, 0, 255);                      // walled-in corner
    s.n_typed = 1; s.typed = '{col: 0, row: 0, cost: 0, last: 1};
    tbl.insert(tbl.size(), s);
    tbl.insert(tbl.size(), mk(KIND_LOAD, 4, 4, 1, 9, 0));
    tbl.insert(tbl.size(), mk(KIND_QUERY, 4, 4, 0, 0, 3));    // blocked origin
    tbl.insert(tbl.size(), mk(KIND_LOAD, 5, 5, 0, 15, 0));
    tbl.insert(tbl.size(), mk(KIND_LOAD, 7, 0, 0, 8, 0));
    tbl.insert(tbl.size(), mk(KIND_QUERY, 6, 6, 1, 15, 255));
    tbl.insert(tbl.size(), mk(KIND_QUERY, 7, 0, 0, 0, 2));
    tbl.insert(tbl.size(), mk(KIND_QUERY, 2, 5, 0, 0, 128));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (tbl[i]) begin
      send_beat(tbl[i]);
      idle_gap();
    end
    drain_wait();

    // Random phase A: cell loads, then well-formed query bursts
    for (int i = 0; i < 440; i++) begin
      send_beat(rand_item(i < 60 ? 0 : 20));
      idle_gap();
      if (i == 200) begin
        // Pause the sender until the block is empty
        drain_wait();
      end
    end

    // Long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
      begin
        for (int i = 0; i < 20; i++) send_beat(rand_item(50));
      end
    join
    drain_wait();
    repeat (150) @(posedge clk_i);

    $display("Covered %0d loads and %0d queries, %0d reached-cell beats checked.",
             n_loads, n_queries, n_beats);
    if (errors == 0 && reach_q.size() == 0) $display("grid_movement_range: match");
    else $display("grid_movement_range: mismatch");
    $finish;
  end

  initial begin
    #20ms;
    $display("grid_movement_range: mismatch");
    $finish;
  end

endmodule
